### src/aie_pkg.sv
package aie_pkg;

  localparam int RAM_WORDS_DEF   = 61;
  localparam int STACK_DEPTH_DEF = 8;
  localparam int QUEUE_DEPTH     = 2;

  // instruction codes
  localparam logic [4:0] OPC_LDA       = 5'd0;
  localparam logic [4:0] OPC_ADDA      = 5'd1;
  localparam logic [4:0] OPC_SUBA      = 5'd2;
  localparam logic [4:0] OPC_MOVAF     = 5'd3;
  localparam logic [4:0] OPC_PUSHA     = 5'd4;
  localparam logic [4:0] OPC_POPA      = 5'd5;
  localparam logic [4:0] OPC_ANDA      = 5'd6;
  localparam logic [4:0] OPC_ORA       = 5'd7;
  localparam logic [4:0] OPC_XORA      = 5'd8;
  localparam logic [4:0] OPC_RRA       = 5'd9;
  localparam logic [4:0] OPC_RLA       = 5'd10;
  localparam logic [4:0] OPC_INCA      = 5'd11;
  localparam logic [4:0] OPC_DECA      = 5'd12;
  localparam logic [4:0] OPC_BSA       = 5'd13;
  localparam logic [4:0] OPC_BCA       = 5'd14;
  localparam logic [4:0] OPC_CLRA      = 5'd15;
  localparam logic [4:0] OPC_GOTO      = 5'd16;
  localparam logic [4:0] OPC_DISPLAY   = 5'd17;
  localparam logic [4:0] OPC_SETT      = 5'd18;
  localparam logic [4:0] OPC_SETD      = 5'd19;
  localparam logic [4:0] OPC_SETA      = 5'd20;
  localparam logic [4:0] OPC_SLEEP     = 5'd21;
  localparam logic [4:0] OPC_SHOWCLOCK = 5'd22;

  localparam logic [7:0]  SHIFT_LIMIT  = 8'd16;
  localparam logic [15:0] BYTE_MASK    = 16'h00ff;
  localparam logic [7:0]  SECS_PER_MIN = 8'd60;
  localparam logic [7:0]  JUMP_SKIP    = 8'd2;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LDA,
    OP_ADDA,
    OP_SUBA,
    OP_MOVAF,
    OP_PUSHA,
    OP_POPA,
    OP_ANDA,
    OP_ORA,
    OP_XORA,
    OP_RRA,
    OP_RLA,
    OP_INCA,
    OP_DECA,
    OP_BSA,
    OP_BCA,
    OP_CLRA,
    OP_GOTO,
    OP_DISPLAY,
    OP_SETT,
    OP_SETD,
    OP_SETA,
    OP_SLEEP,
    OP_SHOWCLOCK
  } exec_op_t;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_RAM     = 2'd1,
    FAULT_FULL    = 2'd2,
    FAULT_SHALLOW = 2'd3
  } fault_t;

  typedef struct packed {
    logic [4:0] opcode;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
  } instr_t;

  typedef struct packed {
    logic [15:0] acc_value;
    logic        jump_taken;
    logic [7:0]  jump_target;
    logic        show_valid;
    logic [15:0] show_first;
    logic [15:0] show_second;
    fault_t      fault;
  } result_t;

  typedef struct packed {
    exec_op_t   op;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic       small_amount;
    logic       ram_in_range;
    logic [7:0] jump_target;
    logic [2:0] sleep_min;
    logic [5:0] sleep_sec;
  } decoded_t;

endpackage

### src/accumulator_instruction_executor.sv
// accumulator machine executing one instruction per item
// input queue: drive instr and raise push; the item is taken at a clock edge
//   where push is high and full is low. full rises once two decoded items
//   wait for the execute stage
// result queue: while empty is low the oldest result sits on result; raise
//   pop to take it. results leave in instruction order, one per item
// a taken item waits in the decoded queue until the result queue has room;
//   it is then executed, its result is written to the result queue and
//   empty falls once that result is written
// throughput: one item per cycle while the result queue has room, set by
//   the single execute stage, which reads and writes acc, stack and clock
// when pop stays low the result queue fills after two items, the execute
//   stage halts, the decoded queue fills after two more and full rises;
//   nothing is dropped
// reset (rst, synchronous): accumulator, stack count, clock, date and alarm
//   values go to zero, both queues empty and the data ram reads as zero
//   again through per-word valid flags; the block takes items on the cycle
//   after reset
module accumulator_instruction_executor #(
  parameter int RAM_WORDS   = aie_pkg::RAM_WORDS_DEF,
  parameter int STACK_DEPTH = aie_pkg::STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  aie_pkg::instr_t  instr,
  output logic             empty,
  input  logic             pop,
  output aie_pkg::result_t result
);

  aie_pkg::decoded_t op_item;
  logic              op_empty;
  logic              op_pop;

  aie_front #(
    .RAM_WORDS (RAM_WORDS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .instr    (instr),
    .op_pop   (op_pop),
    .op_empty (op_empty),
    .op_item  (op_item)
  );

  aie_back #(
    .RAM_WORDS   (RAM_WORDS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_item  (op_item),
    .op_empty (op_empty),
    .op_pop   (op_pop),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule

### src/aie_fifo.sv
module aie_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

### src/aie_ram.sv
module aie_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 61
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/aie_front.sv
module aie_front #(
  parameter int RAM_WORDS = aie_pkg::RAM_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  aie_pkg::instr_t   instr,
  input  logic              op_pop,
  output logic              op_empty,
  output aie_pkg::decoded_t op_item
);

  aie_pkg::decoded_t dec;
  logic [7:0]        rem;

  always_comb begin
    dec              = '0;
    dec.operand_a    = instr.operand_a;
    dec.operand_b    = instr.operand_b;
    dec.small_amount = (instr.operand_a < aie_pkg::SHIFT_LIMIT);
    dec.ram_in_range = ({1'b0, instr.operand_a} < 9'(RAM_WORDS));
    dec.jump_target  = instr.operand_a + aie_pkg::JUMP_SKIP;

    // split sleep seconds into minutes and seconds, at most four steps of 60
    rem           = instr.operand_a;
    dec.sleep_min = '0;
    if (rem >= 8'(4 * aie_pkg::SECS_PER_MIN)) begin
      dec.sleep_min = 3'd4;
      rem           = rem - 8'(4 * aie_pkg::SECS_PER_MIN);
    end else if (rem >= 8'(3 * aie_pkg::SECS_PER_MIN)) begin
      dec.sleep_min = 3'd3;
      rem           = rem - 8'(3 * aie_pkg::SECS_PER_MIN);
    end else if (rem >= 8'(2 * aie_pkg::SECS_PER_MIN)) begin
      dec.sleep_min = 3'd2;
      rem           = rem - 8'(2 * aie_pkg::SECS_PER_MIN);
    end else if (rem >= aie_pkg::SECS_PER_MIN) begin
      dec.sleep_min = 3'd1;
      rem           = rem - aie_pkg::SECS_PER_MIN;
    end
    dec.sleep_sec = rem[5:0];

    unique case (instr.opcode)
      aie_pkg::OPC_LDA:       dec.op = aie_pkg::OP_LDA;
      aie_pkg::OPC_ADDA:      dec.op = aie_pkg::OP_ADDA;
      aie_pkg::OPC_SUBA:      dec.op = aie_pkg::OP_SUBA;
      aie_pkg::OPC_MOVAF:     dec.op = aie_pkg::OP_MOVAF;
      aie_pkg::OPC_PUSHA:     dec.op = aie_pkg::OP_PUSHA;
      aie_pkg::OPC_POPA:      dec.op = aie_pkg::OP_POPA;
      aie_pkg::OPC_ANDA:      dec.op = aie_pkg::OP_ANDA;
      aie_pkg::OPC_ORA:       dec.op = aie_pkg::OP_ORA;
      aie_pkg::OPC_XORA:      dec.op = aie_pkg::OP_XORA;
      aie_pkg::OPC_RRA:       dec.op = aie_pkg::OP_RRA;
      aie_pkg::OPC_RLA:       dec.op = aie_pkg::OP_RLA;
      aie_pkg::OPC_INCA:      dec.op = aie_pkg::OP_INCA;
      aie_pkg::OPC_DECA:      dec.op = aie_pkg::OP_DECA;
      aie_pkg::OPC_BSA:       dec.op = aie_pkg::OP_BSA;
      aie_pkg::OPC_BCA:       dec.op = aie_pkg::OP_BCA;
      aie_pkg::OPC_CLRA:      dec.op = aie_pkg::OP_CLRA;
      aie_pkg::OPC_GOTO:      dec.op = aie_pkg::OP_GOTO;
      aie_pkg::OPC_DISPLAY:   dec.op = aie_pkg::OP_DISPLAY;
      aie_pkg::OPC_SETT:      dec.op = aie_pkg::OP_SETT;
      aie_pkg::OPC_SETD:      dec.op = aie_pkg::OP_SETD;
      aie_pkg::OPC_SETA:      dec.op = aie_pkg::OP_SETA;
      aie_pkg::OPC_SLEEP:     dec.op = aie_pkg::OP_SLEEP;
      aie_pkg::OPC_SHOWCLOCK: dec.op = aie_pkg::OP_SHOWCLOCK;
      default:                dec.op = aie_pkg::OP_NOP;
    endcase
  end

  aie_fifo #(
    .WIDTH ($bits(aie_pkg::decoded_t)),
    .DEPTH (aie_pkg::QUEUE_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (dec),
    .full  (full),
    .pop   (op_pop),
    .rdata (op_item),
    .empty (op_empty)
  );

endmodule

### src/aie_back.sv
module aie_back #(
  parameter int RAM_WORDS   = aie_pkg::RAM_WORDS_DEF,
  parameter int STACK_DEPTH = aie_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  aie_pkg::decoded_t op_item,
  input  logic              op_empty,
  output logic              op_pop,
  input  logic              pop,
  output logic              empty,
  output aie_pkg::result_t  result
);

  localparam int RAM_AW = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W  = $clog2(STACK_DEPTH);

  logic [15:0]      acc;
  logic [15:0]      acc_next;
  logic [7:0]       stack [STACK_DEPTH];
  logic [CNT_W-1:0] stack_count;
  logic [CNT_W-1:0] stack_count_next;
  logic [CNT_W-1:0] count_dec;
  logic             stack_we;
  logic [15:0]      clk_min;
  logic [15:0]      clk_min_next;
  logic [15:0]      clk_sec;
  logic [15:0]      clk_sec_next;
  logic [15:0]      date_first;
  logic [15:0]      date_second;
  logic [15:0]      alarm_first;
  logic [15:0]      alarm_second;
  logic             exec;
  logic             res_full;
  aie_pkg::result_t res;

  logic              ram_we;
  logic [RAM_WORDS-1:0] ram_valid;
  logic [RAM_AW-1:0] chk_addr;
  logic [15:0]       chk_data;
  logic [15:0]       chk_expect;
  logic              chk_armed;
  logic              chk_due;
  logic              chk_hit;
  logic [15:0]       ram_rdata;
  logic [15:0]       ram_view;

  assign exec      = !op_empty && !res_full;
  assign op_pop    = exec;
  assign count_dec = stack_count - CNT_W'(1);

  always_comb begin
    acc_next         = acc;
    stack_count_next = stack_count;
    stack_we         = 1'b0;
    clk_min_next     = clk_min;
    clk_sec_next     = clk_sec;
    ram_we           = 1'b0;
    res              = '0;
    res.fault        = aie_pkg::FAULT_NONE;

    case (op_item.op)
      aie_pkg::OP_LDA:  acc_next = 16'(op_item.operand_a);
      aie_pkg::OP_ADDA: acc_next = acc + 16'(op_item.operand_a);
      aie_pkg::OP_SUBA: acc_next = acc - 16'(op_item.operand_a);
      aie_pkg::OP_MOVAF: begin
        if (op_item.ram_in_range) begin
          ram_we = 1'b1;
        end else begin
          res.fault = aie_pkg::FAULT_RAM;
        end
      end
      aie_pkg::OP_PUSHA: begin
        if (stack_count >= CNT_W'(STACK_DEPTH)) begin
          res.fault = aie_pkg::FAULT_FULL;
        end else begin
          stack_we         = 1'b1;
          stack_count_next = stack_count + CNT_W'(1);
        end
      end
      aie_pkg::OP_POPA: begin
        if (stack_count == '0) begin
          res.fault = aie_pkg::FAULT_SHALLOW;
        end else begin
          acc_next         = 16'(stack[count_dec[IDX_W-1:0]]);
          stack_count_next = count_dec;
        end
      end
      aie_pkg::OP_ANDA: acc_next = acc & 16'(op_item.operand_a);
      aie_pkg::OP_ORA:  acc_next = acc | 16'(op_item.operand_a);
      aie_pkg::OP_XORA: acc_next = acc ^ 16'(op_item.operand_a);
      aie_pkg::OP_RRA:
        acc_next = op_item.small_amount ? (acc >> op_item.operand_a[3:0]) : '0;
      aie_pkg::OP_RLA:
        acc_next = op_item.small_amount ? (acc << op_item.operand_a[3:0]) : '0;
      aie_pkg::OP_INCA: acc_next = acc + 16'd1;
      aie_pkg::OP_DECA: acc_next = acc - 16'd1;
      aie_pkg::OP_BSA: begin
        if (op_item.small_amount) begin
          acc_next = acc | (16'd1 << op_item.operand_a[3:0]);
        end
      end
      aie_pkg::OP_BCA: begin
        // clear upper byte, keep chosen bit 8 to 15, clear chosen bit 0 to 7
        if (op_item.small_amount) begin
          acc_next = acc & ((16'd1 << op_item.operand_a[3:0]) ^ aie_pkg::BYTE_MASK);
        end else begin
          acc_next = acc & aie_pkg::BYTE_MASK;
        end
      end
      aie_pkg::OP_CLRA: acc_next = '0;
      aie_pkg::OP_GOTO: begin
        res.jump_taken  = 1'b1;
        res.jump_target = op_item.jump_target;
      end
      aie_pkg::OP_DISPLAY: begin
        if (stack_count < CNT_W'(2)) begin
          res.fault = aie_pkg::FAULT_SHALLOW;
        end else begin
          res.show_valid  = 1'b1;
          res.show_first  = 16'(stack[0]);
          res.show_second = 16'(stack[1]);
        end
      end
      aie_pkg::OP_SLEEP: begin
        // no carry from seconds into minutes
        clk_min_next    = clk_min + 16'(op_item.sleep_min);
        clk_sec_next    = clk_sec + 16'(op_item.sleep_sec);
        res.show_valid  = 1'b1;
        res.show_first  = clk_min_next;
        res.show_second = clk_sec_next;
      end
      aie_pkg::OP_SHOWCLOCK: begin
        res.show_valid  = 1'b1;
        res.show_first  = clk_min;
        res.show_second = clk_sec;
      end
      aie_pkg::OP_SETT: begin
        clk_min_next = 16'(op_item.operand_a);
        clk_sec_next = 16'(op_item.operand_b);
      end
      default: begin
      end
    endcase

    res.acc_value = acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      stack_count  <= '0;
      clk_min      <= '0;
      clk_sec      <= '0;
      date_first   <= '0;
      date_second  <= '0;
      alarm_first  <= '0;
      alarm_second <= '0;
    end else if (exec) begin
      acc         <= acc_next;
      stack_count <= stack_count_next;
      clk_min     <= clk_min_next;
      clk_sec     <= clk_sec_next;
      if (op_item.op == aie_pkg::OP_SETD) begin
        date_first  <= 16'(op_item.operand_a);
        date_second <= 16'(op_item.operand_b);
      end
      if (op_item.op == aie_pkg::OP_SETA) begin
        alarm_first  <= 16'(op_item.operand_a);
        alarm_second <= 16'(op_item.operand_b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec && stack_we) begin
      stack[stack_count[IDX_W-1:0]] <= op_item.operand_a;
    end
  end

  // data ram: entries not yet written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_valid <= '0;
      chk_armed <= 1'b0;
      chk_due   <= 1'b0;
    end else begin
      if (exec && ram_we) begin
        ram_valid[op_item.operand_a[RAM_AW-1:0]] <= 1'b1;
      end
      chk_armed <= exec && ram_we;
      chk_due   <= chk_armed;
    end
  end

  // read back the last stored word
  always_ff @(posedge clk) begin
    if (exec && ram_we) begin
      chk_addr <= op_item.operand_a[RAM_AW-1:0];
      chk_data <= acc;
    end
    chk_expect <= chk_data;
    chk_hit    <= ram_valid[chk_addr];
  end

  assign ram_view = chk_hit ? ram_rdata : '0;

  aie_ram #(
    .WIDTH (16),
    .DEPTH (RAM_WORDS)
  ) u_data_ram (
    .clk   (clk),
    .we    (exec && ram_we),
    .waddr (op_item.operand_a[RAM_AW-1:0]),
    .wdata (acc),
    .raddr (chk_addr),
    .rdata (ram_rdata)
  );

  aie_fifo #(
    .WIDTH ($bits(aie_pkg::result_t)),
    .DEPTH (aie_pkg::QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (exec),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (exec && op_item.op == aie_pkg::OP_PUSHA && stack_count < CNT_W'(STACK_DEPTH))
    |=> (stack_count == $past(stack_count) + CNT_W'(1)))
    else $error("push did not grow the stack");

  a_push_full_holds: assert property (@(posedge clk) disable iff (rst)
    (exec && op_item.op == aie_pkg::OP_PUSHA && stack_count == CNT_W'(STACK_DEPTH))
    |=> $stable(stack_count))
    else $error("push on a full stack changed the count");

  a_ram_readback: assert property (@(posedge clk) disable iff (rst)
    chk_due |-> (ram_view == chk_expect))
    else $error("data ram read back a different word");

endmodule
